### hdl/descriptor_nearest_match_core_defines.svh
// Assertion macros for the descriptor nearest-match core.
// Included by the top level; no other dependencies.
`ifndef DESCRIPTOR_NEAREST_MATCH_CORE_DEFINES_SVH
`define DESCRIPTOR_NEAREST_MATCH_CORE_DEFINES_SVH

// same-cycle implication
`define DNM_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("dnm check failed");

// next-cycle implication
`define DNM_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("dnm check failed");

`endif

### hdl/dnm_pkg.sv
// Shared constants, register indexes and controller/datapath structs
// for the descriptor nearest-match core. No dependencies.
package dnm_pkg;

  localparam int MAX_REFERENCES = 1024;
  localparam int MAX_DIM        = 64;
  localparam int STORE_DEPTH    = MAX_REFERENCES * MAX_DIM;
  localparam int STORE_AW       = $clog2(STORE_DEPTH);

  localparam int REF_IDX_W  = $clog2(MAX_REFERENCES);
  localparam int ELEM_IDX_W = $clog2(MAX_DIM);
  localparam int VALUE_W    = 16;
  localparam int LEN_W      = 7;
  localparam int COUNT_W    = 11;
  localparam int DIST_W     = 39;
  localparam int SQ_W       = 32;
  localparam int QIDX_W     = 16;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 39;

  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 72;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_DESCRIPTOR_LENGTH = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_REFERENCE_COUNT   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_MATCH_THRESHOLD   = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_MISMATCH_DISTANCE = 2'd3;

  // register reset values
  localparam logic [LEN_W-1:0]   RST_DESCRIPTOR_LENGTH = 7'd64;
  localparam logic [COUNT_W-1:0] RST_REFERENCE_COUNT   = 11'd0;
  localparam logic [DIST_W-1:0]  RST_MATCH_THRESHOLD   = 39'd8697308;
  localparam logic [DIST_W-1:0]  RST_MISMATCH_DISTANCE = 39'd107374182400;

  // item kinds
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic                  accept;         // input transfer this cycle
    logic                  issue;          // read one element pair
    logic [REF_IDX_W-1:0]  ref_idx;
    logic [ELEM_IDX_W-1:0] elem_idx;
    logic                  first;
    logic                  last;
    logic                  publish;        // load search result into output
    logic                  publish_empty;  // load no-references result
  } dnm_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic                  out_free;
    logic                  trigger;        // current item completes a query
    logic                  count_zero;
    logic [ELEM_IDX_W-1:0] len_last;
    logic [REF_IDX_W-1:0]  count_last;
    logic                  pipe_empty;
  } dnm_status_t;

endpackage

### hdl/descriptor_nearest_match_core.sv
// Descriptor nearest-match core. A query's last element starts a scan for the
// best match; with no references its result is published without a scan.
// Loads and non-final query elements are accepted one per cycle while the
// output is free; the scan holds input, running one MAC per cycle on the
// single reference-store read port. Reset (rst, synchronous) restores the
// register defaults and zeroes the query counter; stored descriptors are kept.
`include "descriptor_nearest_match_core_defines.svh"

module descriptor_nearest_match_core (
  input  logic                                 clk,
  input  logic                                 rst,
  // input stream
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [9:0] entry_index, [15:10] element_index, [31:16] element_value,
  // [32] sign_bit, [39:33] zero
  input  logic [dnm_pkg::S_TDATA_W-1:0]        s_axis_tdata,
  // [0] cmd
  input  logic [0:0]                           s_axis_tuser,
  // result stream
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [15:0] query_index, [25:16] best_index, [64:26] best_distance_sq,
  // [65] matched, [71:66] zero
  output logic [dnm_pkg::M_TDATA_W-1:0]        m_axis_tdata,
  // [0] no_references
  output logic [0:0]                           m_axis_tuser,
  // configuration
  input  logic                                 cfg_we,
  input  logic [dnm_pkg::CFG_ADDR_W-1:0]       cfg_addr,
  input  logic [dnm_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  dnm_pkg::dnm_cmd_t    cmd;
  dnm_pkg::dnm_status_t stat;

  logic [dnm_pkg::QIDX_W-1:0]    res_query_index;
  logic [dnm_pkg::REF_IDX_W-1:0] res_best_index;
  logic [dnm_pkg::DIST_W-1:0]    res_best_distance_sq;
  logic                          res_matched;
  logic                          res_no_references;

  dnm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dnm_datapath u_datapath (
    .clk                  (clk),
    .rst                  (rst),
    .cmd                  (cmd),
    .stat                 (stat),
    .cfg_we               (cfg_we),
    .cfg_addr             (cfg_addr),
    .cfg_wdata            (cfg_wdata),
    .in_cmd               (s_axis_tuser[0]),
    .in_entry_index       (s_axis_tdata[9:0]),
    .in_element_index     (s_axis_tdata[15:10]),
    .in_element_value     (s_axis_tdata[31:16]),
    .in_sign_bit          (s_axis_tdata[32]),
    .out_ready            (m_axis_tready),
    .out_valid            (m_axis_tvalid),
    .out_query_index      (res_query_index),
    .out_best_index       (res_best_index),
    .out_best_distance_sq (res_best_distance_sq),
    .out_matched          (res_matched),
    .out_no_references    (res_no_references)
  );

  assign m_axis_tdata = {6'd0, res_matched, res_best_distance_sq,
                         res_best_index, res_query_index};
  assign m_axis_tuser = res_no_references;

  // no input transfer while the MAC pipeline still holds work
  `DNM_ASSERT_IMP(a_ready_only_when_drained, clk, rst, s_axis_tready, stat.pipe_empty)
  // an empty-store answer carries all-zero fields
  `DNM_ASSERT_IMP(a_empty_result_zero, clk, rst, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == '0)
  // a published result shows up on the output the next cycle
  `DNM_ASSERT_NXT(a_publish_shows, clk, rst, cmd.publish || cmd.publish_empty, m_axis_tvalid)

endmodule

### hdl/dnm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dnm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/dnm_ctrl.sv
// Controller FSM: input acceptance and the reference/element scan.
// Depends on dnm_pkg.
module dnm_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  dnm_pkg::dnm_status_t stat,
  output dnm_pkg::dnm_cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t                           state, state_next;
  logic [dnm_pkg::REF_IDX_W-1:0]    ref_cnt, ref_cnt_next;
  logic [dnm_pkg::ELEM_IDX_W-1:0]   elem_cnt, elem_cnt_next;
  logic                             accept;
  logic                             elem_last;

  assign in_ready  = (state == ST_IDLE) && stat.out_free;
  assign accept    = in_valid && in_ready;
  assign elem_last = (elem_cnt == stat.len_last);

  always_comb begin
    state_next    = state;
    ref_cnt_next  = ref_cnt;
    elem_cnt_next = elem_cnt;
    cmd           = '0;
    cmd.accept    = accept;
    cmd.ref_idx   = ref_cnt;
    cmd.elem_idx  = elem_cnt;
    cmd.first     = (elem_cnt == '0);
    cmd.last      = elem_last;
    case (state)
      ST_IDLE: begin
        if (accept && stat.trigger) begin
          if (stat.count_zero) begin
            cmd.publish_empty = 1'b1;
          end else begin
            state_next    = ST_SCAN;
            ref_cnt_next  = '0;
            elem_cnt_next = '0;
          end
        end
      end
      ST_SCAN: begin
        cmd.issue = 1'b1;
        if (elem_last) begin
          elem_cnt_next = '0;
          if (ref_cnt == stat.count_last) begin
            state_next = ST_DRAIN;
          end else begin
            ref_cnt_next = ref_cnt + 1'b1;
          end
        end else begin
          elem_cnt_next = elem_cnt + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (stat.pipe_empty) begin
          cmd.publish = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      ref_cnt  <= '0;
      elem_cnt <= '0;
    end else begin
      state    <= state_next;
      ref_cnt  <= ref_cnt_next;
      elem_cnt <= elem_cnt_next;
    end
  end

endmodule

### hdl/dnm_datapath.sv
// Datapath: config registers, descriptor stores, squared-distance MAC
// pipeline, best-match tracking and output register.
// Depends on dnm_pkg and dnm_ram.
module dnm_datapath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  dnm_pkg::dnm_cmd_t                     cmd,
  output dnm_pkg::dnm_status_t                  stat,
  // configuration
  input  logic                                  cfg_we,
  input  logic [dnm_pkg::CFG_ADDR_W-1:0]        cfg_addr,
  input  logic [dnm_pkg::CFG_DATA_W-1:0]        cfg_wdata,
  // input item
  input  logic                                  in_cmd,
  input  logic [dnm_pkg::REF_IDX_W-1:0]         in_entry_index,
  input  logic [dnm_pkg::ELEM_IDX_W-1:0]        in_element_index,
  input  logic signed [dnm_pkg::VALUE_W-1:0]    in_element_value,
  input  logic                                  in_sign_bit,
  // result
  input  logic                                  out_ready,
  output logic                                  out_valid,
  output logic [dnm_pkg::QIDX_W-1:0]            out_query_index,
  output logic [dnm_pkg::REF_IDX_W-1:0]         out_best_index,
  output logic [dnm_pkg::DIST_W-1:0]            out_best_distance_sq,
  output logic                                  out_matched,
  output logic                                  out_no_references
);

  // configuration
  logic [dnm_pkg::LEN_W-1:0]   desc_len;
  logic [dnm_pkg::COUNT_W-1:0] ref_count;
  logic [dnm_pkg::DIST_W-1:0]  match_thr;
  logic [dnm_pkg::DIST_W-1:0]  mismatch_dist;

  logic [dnm_pkg::LEN_W-1:0]   len_eff;
  logic [dnm_pkg::COUNT_W-1:0] count_eff;

  logic                        query_sign;
  logic [dnm_pkg::QIDX_W-1:0]  query_cnt;

  // store interfaces
  logic                         load_we, sign_we, query_we;
  logic [dnm_pkg::VALUE_W-1:0]  ref_rd, q_rd;
  logic                         sign_rd;

  // pipeline
  logic                          vb, firstb, lastb;
  logic [dnm_pkg::REF_IDX_W-1:0] nb;
  logic                          vc, firstc, lastc, matchc;
  logic [dnm_pkg::REF_IDX_W-1:0] nc;
  logic [dnm_pkg::SQ_W-1:0]      sqc;
  logic [dnm_pkg::DIST_W-1:0]    acc, acc_sum;
  logic                          vd;
  logic [dnm_pkg::DIST_W-1:0]    cand_dist;
  logic [dnm_pkg::REF_IDX_W-1:0] cand_n;
  logic [dnm_pkg::DIST_W-1:0]    best_dist;
  logic [dnm_pkg::REF_IDX_W-1:0] best_n;

  logic signed [dnm_pkg::VALUE_W:0]     diff;
  logic signed [2*dnm_pkg::VALUE_W+1:0] prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      desc_len      <= dnm_pkg::RST_DESCRIPTOR_LENGTH;
      ref_count     <= dnm_pkg::RST_REFERENCE_COUNT;
      match_thr     <= dnm_pkg::RST_MATCH_THRESHOLD;
      mismatch_dist <= dnm_pkg::RST_MISMATCH_DISTANCE;
    end else if (cfg_we) begin
      case (cfg_addr)
        dnm_pkg::REG_DESCRIPTOR_LENGTH: desc_len      <= cfg_wdata[dnm_pkg::LEN_W-1:0];
        dnm_pkg::REG_REFERENCE_COUNT:   ref_count     <= cfg_wdata[dnm_pkg::COUNT_W-1:0];
        dnm_pkg::REG_MATCH_THRESHOLD:   match_thr     <= cfg_wdata[dnm_pkg::DIST_W-1:0];
        dnm_pkg::REG_MISMATCH_DISTANCE: mismatch_dist <= cfg_wdata[dnm_pkg::DIST_W-1:0];
        default: ;
      endcase
    end
  end

  // length 0 acts as 1, oversize values clamp to the store limits
  always_comb begin
    if (desc_len == '0) begin
      len_eff = dnm_pkg::LEN_W'(1);
    end else if (desc_len > dnm_pkg::LEN_W'(dnm_pkg::MAX_DIM)) begin
      len_eff = dnm_pkg::LEN_W'(dnm_pkg::MAX_DIM);
    end else begin
      len_eff = desc_len;
    end
    if (ref_count > dnm_pkg::COUNT_W'(dnm_pkg::MAX_REFERENCES)) begin
      count_eff = dnm_pkg::COUNT_W'(dnm_pkg::MAX_REFERENCES);
    end else begin
      count_eff = ref_count;
    end
  end

  logic [dnm_pkg::LEN_W-1:0]   len_m1;
  logic [dnm_pkg::COUNT_W-1:0] count_m1;
  assign len_m1   = len_eff - 1'b1;
  assign count_m1 = count_eff - 1'b1;

  assign stat.len_last   = len_m1[dnm_pkg::ELEM_IDX_W-1:0];
  assign stat.count_last = count_m1[dnm_pkg::REF_IDX_W-1:0];
  assign stat.count_zero = (ref_count == '0);
  assign stat.trigger    = (in_cmd == dnm_pkg::CMD_QUERY) &&
                           (in_element_index == stat.len_last);
  assign stat.out_free   = !out_valid || out_ready;
  assign stat.pipe_empty = !vb && !vc && !vd;

  // stores
  assign load_we  = cmd.accept && (in_cmd == dnm_pkg::CMD_LOAD);
  assign sign_we  = load_we && (in_element_index == '0);
  assign query_we = cmd.accept && (in_cmd == dnm_pkg::CMD_QUERY);

  dnm_ram #(.WIDTH(dnm_pkg::VALUE_W), .DEPTH(dnm_pkg::STORE_DEPTH)) u_ref_store (
    .clk   (clk),
    .we    (load_we),
    .waddr (dnm_pkg::STORE_AW'({in_entry_index, in_element_index})),
    .wdata (in_element_value),
    .raddr (dnm_pkg::STORE_AW'({cmd.ref_idx, cmd.elem_idx})),
    .rdata (ref_rd)
  );

  dnm_ram #(.WIDTH(1), .DEPTH(dnm_pkg::MAX_REFERENCES)) u_ref_signs (
    .clk   (clk),
    .we    (sign_we),
    .waddr (in_entry_index),
    .wdata (in_sign_bit),
    .raddr (cmd.ref_idx),
    .rdata (sign_rd)
  );

  dnm_ram #(.WIDTH(dnm_pkg::VALUE_W), .DEPTH(dnm_pkg::MAX_DIM)) u_query_buf (
    .clk   (clk),
    .we    (query_we),
    .waddr (in_element_index),
    .wdata (in_element_value),
    .raddr (cmd.elem_idx),
    .rdata (q_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      query_sign <= 1'b0;
    end else if (query_we && (in_element_index == '0)) begin
      query_sign <= in_sign_bit;
    end
  end

  // stage B: RAM read data; stage C: square; stage D: candidate distance
  assign diff = $signed({q_rd[dnm_pkg::VALUE_W-1], q_rd}) -
                $signed({ref_rd[dnm_pkg::VALUE_W-1], ref_rd});
  assign prod = diff * diff;
  assign acc_sum = (firstc ? '0 : acc) + dnm_pkg::DIST_W'(sqc);

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
    end else begin
      vb <= cmd.issue;
      vc <= vb;
      vd <= vc && lastc;
    end
  end

  always_ff @(posedge clk) begin
    firstb <= cmd.first;
    lastb  <= cmd.last;
    nb     <= cmd.ref_idx;
    firstc <= firstb;
    lastc  <= lastb;
    nc     <= nb;
    matchc <= (sign_rd == query_sign);
    sqc    <= prod[dnm_pkg::SQ_W-1:0];
    if (vc) begin
      acc <= acc_sum;
    end
    cand_dist <= matchc ? acc_sum : mismatch_dist;
    cand_n    <= nc;
    // strict compare keeps the lowest index on ties
    if (vd && ((cand_n == '0) || (cand_dist < best_dist))) begin
      best_dist <= cand_dist;
      best_n    <= cand_n;
    end
  end

  // output register and query sequence number
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      query_cnt <= '0;
    end else begin
      if (cmd.publish || cmd.publish_empty) begin
        out_valid <= 1'b1;
        query_cnt <= query_cnt + 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_query_index      <= query_cnt;
      out_best_index       <= best_n;
      out_best_distance_sq <= best_dist;
      out_matched          <= (best_dist < match_thr);
      out_no_references    <= 1'b0;
    end else if (cmd.publish_empty) begin
      out_query_index      <= '0;
      out_best_index       <= '0;
      out_best_distance_sq <= '0;
      out_matched          <= 1'b0;
      out_no_references    <= 1'b1;
    end
  end

endmodule

### tb/tb_descriptor_nearest_match_core.sv
// Self-checking bench for descriptor_nearest_match_core: streams reference loads and
// queries, predicts each nearest-match result in-bench and checks it per field.
// Depends on dnm_pkg and the core RTL only.
`timescale 1ns / 100ps

module tb_descriptor_nearest_match_core;
  import dnm_pkg::*;

  localparam int CYCLE_LIMIT = 60_000;
  localparam int DRAIN_CYCLES = 16;
  localparam logic [DIST_W-1:0] DIST_ALL_ONES = '1;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
  typedef enum {Q_EXACT, Q_NEAR, Q_RANDOM} query_kind_t;

  typedef struct packed {
    logic                  cmd;
    logic [REF_IDX_W-1:0]  entry;
    logic [ELEM_IDX_W-1:0] elem;
    logic [VALUE_W-1:0]    value;
    logic                  sgn;
  } xfer_t;

  typedef struct packed {
    logic [QIDX_W-1:0]    query_index;
    logic [REF_IDX_W-1:0] best_index;
    logic [DIST_W-1:0]    best_distance;
    logic                 matched;
    logic                 no_refs;
  } match_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic [0:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [0:0] m_axis_tuser;
  logic cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  descriptor_nearest_match_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata)
  );

  always #2 clk = ~clk;

  // register copies, shared by stimulus and predictor (written only while idle)
  logic [LEN_W-1:0]   cfg_len       = RST_DESCRIPTOR_LENGTH;
  logic [COUNT_W-1:0] cfg_count     = RST_REFERENCE_COUNT;
  logic [DIST_W-1:0]  cfg_threshold = RST_MATCH_THRESHOLD;
  logic [DIST_W-1:0]  cfg_mismatch  = RST_MISMATCH_DISTANCE;

  // predictor state, updated at each accepted transfer
  logic [VALUE_W-1:0] desc_store [STORE_DEPTH];
  logic               desc_signs [MAX_REFERENCES];
  logic [VALUE_W-1:0] query_elems [MAX_DIM];
  logic               query_sign = 1'b0;
  logic [QIDX_W-1:0]  query_count = '0;

  // stimulus-side mirror of the store, runs ahead of the predictor
  bit [VALUE_W-1:0] gen_store [STORE_DEPTH];
  bit               gen_written [STORE_DEPTH];
  bit               gen_signs [MAX_REFERENCES];

  xfer_t         pending[$];
  xfer_t         cur_xfer;
  match_result_t match_expected[$];

  int pushed_count = 0;
  int accepted_count = 0;
  int results_checked = 0;
  int matched_seen = 0;
  int empty_seen = 0;
  int errors = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  function automatic int eff_len();
    if (cfg_len == 0) return 1;
    if (cfg_len > MAX_DIM) return MAX_DIM;
    return int'(cfg_len);
  endfunction

  function automatic int eff_count();
    if (cfg_count > MAX_REFERENCES) return MAX_REFERENCES;
    return int'(cfg_count);
  endfunction

  function automatic void predict_transfer(xfer_t x);
    int len;
    int cnt;
    int d;
    int best_n;
    longint acc;
    longint cand_d;
    longint best;
    match_result_t r;
    if (x.cmd == CMD_LOAD) begin
      desc_store[int'(x.entry) * MAX_DIM + int'(x.elem)] = x.value;
      if (x.elem == 0) desc_signs[x.entry] = x.sgn;
    end else begin
      query_elems[x.elem] = x.value;
      if (x.elem == 0) query_sign = x.sgn;
      len = eff_len();
      if (int'(x.elem) == len - 1) begin
        cnt = eff_count();
        r = '0;
        best = 0;
        best_n = 0;
        if (cnt == 0) begin
          r.no_refs = 1'b1;
        end else begin
          for (int n = 0; n < cnt; n++) begin
            if (desc_signs[n] == query_sign) begin
              acc = 0;
              for (int k = 0; k < len; k++) begin
                d = int'($signed(query_elems[k])) - int'($signed(desc_store[n * MAX_DIM + k]));
                acc += longint'(d) * longint'(d);
              end
              cand_d = (acc > longint'(DIST_ALL_ONES)) ? longint'(DIST_ALL_ONES) : acc;
            end else begin
              cand_d = longint'(cfg_mismatch);
            end
            if (n == 0 || cand_d < best) begin
              best = cand_d;
              best_n = n;
            end
          end
          r.query_index = query_count;
          r.best_index = best_n[REF_IDX_W-1:0];
          r.best_distance = best[DIST_W-1:0];
          r.matched = best < longint'(cfg_threshold);
        end
        match_expected.insert(match_expected.size(), r);
        query_count++;
      end
    end
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endfunction

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_transfer(cur_xfer);
        accepted_count++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_xfer = pending.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {7'b0, cur_xfer.sgn, cur_xfer.value, cur_xfer.elem, cur_xfer.entry};
          s_axis_tuser <= cur_xfer.cmd;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    match_result_t got;
    match_result_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.query_index = m_axis_tdata[15:0];
        got.best_index = m_axis_tdata[25:16];
        got.best_distance = m_axis_tdata[64:26];
        got.matched = m_axis_tdata[65];
        got.no_refs = m_axis_tuser[0];
        if (match_expected.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual query %0d best %0d dist %0d",
                   $time, got.query_index, got.best_index, got.best_distance);
        end else begin
          want = match_expected.pop_front();
          check_field("query_index", 64'(want.query_index), 64'(got.query_index));
          check_field("best_index", 64'(want.best_index), 64'(got.best_index));
          check_field("best_distance_sq", 64'(want.best_distance), 64'(got.best_distance));
          check_field("matched", 64'(want.matched), 64'(got.matched));
          check_field("no_references", 64'(want.no_refs), 64'(got.no_refs));
          results_checked++;
          if (want.matched) matched_seen++;
          if (want.no_refs) empty_seen++;
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still outstanding", $time, match_expected.size());
      $display("tb_descriptor_nearest_match_core: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [VALUE_W-1:0] nudge(logic [VALUE_W-1:0] base, int spread);
    int v;
    v = int'($signed(base)) + int'($urandom_range(2 * spread)) - spread;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[VALUE_W-1:0];
  endfunction

  function automatic logic [DIST_W-1:0] rand39();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[DIST_W-1:0];
  endfunction

  task automatic push_item(logic cmd, logic [REF_IDX_W-1:0] entry, logic [ELEM_IDX_W-1:0] elem,
                           logic [VALUE_W-1:0] value, logic sgn);
    xfer_t x;
    x = '{cmd: cmd, entry: entry, elem: elem, value: value, sgn: sgn};
    pending.insert(pending.size(), x);
    pushed_count++;
    if (cmd == CMD_LOAD) begin
      gen_store[int'(entry) * MAX_DIM + int'(elem)] = value;
      gen_written[int'(entry) * MAX_DIM + int'(elem)] = 1'b1;
      if (elem == 0) gen_signs[entry] = sgn;
    end
  endtask

  // block is idle once every pushed transfer went in and every result came out
  task automatic wait_drained();
    while (accepted_count != pushed_count || match_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [DIST_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_DESCRIPTOR_LENGTH: cfg_len = val[LEN_W-1:0];
      REG_REFERENCE_COUNT:   cfg_count = val[COUNT_W-1:0];
      REG_MATCH_THRESHOLD:   cfg_threshold = val;
      REG_MISMATCH_DISTANCE: cfg_mismatch = val;
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_idling(idle_mode_t mode);
    case (mode)
      IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SENDER:   begin send_idle_pct = 79; recv_stall_pct = 0;  end
      IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 79; end
      IDLE_BOTH:     begin send_idle_pct = 22; recv_stall_pct = 22; end
      default:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
    endcase
  endtask

  // every entry in the searched range gets its first len elements written;
  // small sets are sometimes reloaded with fresh content
  task automatic fill_refs();
    int len;
    int cnt;
    bit fresh;
    len = eff_len();
    cnt = eff_count();
    for (int n = 0; n < cnt; n++) begin
      fresh = (cnt * len <= 64) && ($urandom_range(2) == 0);
      for (int k = 0; k < len; k++)
        if (fresh || !gen_written[n * MAX_DIM + k])
          push_item(CMD_LOAD, 10'(n), 6'(k), pick_value(), 1'($urandom_range(1)));
    end
  endtask

  task automatic send_query();
    int len;
    int cnt;
    int src;
    int spread;
    int r;
    int k;
    bit up;
    logic sgn;
    query_kind_t kind;
    logic [VALUE_W-1:0] vals [MAX_DIM];
    len = eff_len();
    cnt = eff_count();
    src = (cnt > 0) ? $urandom_range(cnt - 1) : 0;
    r = $urandom_range(9);
    kind = (r < 2) ? Q_EXACT : (r < 7) ? Q_NEAR : Q_RANDOM;
    case ($urandom_range(3))
      0: spread = 16;
      1: spread = 256;
      2: spread = 2048;
      default: spread = 16384;
    endcase
    sgn = gen_signs[src];
    if (kind == Q_RANDOM || $urandom_range(7) == 0) sgn = 1'($urandom_range(1));
    for (int i = 0; i < len; i++) begin
      case (kind)
        Q_EXACT: vals[i] = gen_store[src * MAX_DIM + i];
        Q_NEAR:  vals[i] = nudge(gen_store[src * MAX_DIM + i], spread);
        default: vals[i] = pick_value();
      endcase
    end
    up = 1'($urandom_range(1));
    for (int i = 0; i < len - 1; i++) begin
      k = up ? i : len - 2 - i;
      push_item(CMD_QUERY, 10'($urandom()), 6'(k), vals[k],
                (k == 0) ? sgn : 1'($urandom_range(1)));
      // element past the descriptor end: stored, never completes a query
      if ($urandom_range(15) == 0 && len < MAX_DIM)
        push_item(CMD_QUERY, 10'($urandom()), 6'($urandom_range(MAX_DIM - 1, len)),
                  pick_value(), 1'($urandom_range(1)));
    end
    push_item(CMD_QUERY, 10'($urandom()), 6'(len - 1), vals[len - 1],
              (len == 1) ? sgn : 1'($urandom_range(1)));
  endtask

  task automatic run_phase(int len_w, int cnt_w, logic [DIST_W-1:0] thr,
                           logic [DIST_W-1:0] mis, int queries, idle_mode_t mode);
    int len;
    int r;
    wait_drained();
    write_reg(REG_DESCRIPTOR_LENGTH, DIST_W'(len_w));
    write_reg(REG_REFERENCE_COUNT, DIST_W'(cnt_w));
    write_reg(REG_MATCH_THRESHOLD, thr);
    write_reg(REG_MISMATCH_DISTANCE, mis);
    end_writes();
    set_idling(mode);
    fill_refs();
    len = eff_len();
    repeat (queries) begin
      r = $urandom_range(9);
      if (r == 0) begin
        push_item(CMD_LOAD, 10'($urandom()), 6'($urandom()), pick_value(),
                  1'($urandom_range(1)));
      end else if (r == 1 && len > 1) begin
        // abandoned query: a prefix that never reaches its last element
        repeat ($urandom_range(len - 1, 1)) begin end
        for (int k = 0; k < $urandom_range(len - 1, 1); k++)
          push_item(CMD_QUERY, 10'($urandom()), 6'(k), pick_value(), 1'($urandom_range(1)));
      end
      send_query();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed part
    set_idling(IDLE_NONE);
    write_reg(REG_DESCRIPTOR_LENGTH, DIST_W'(2));
    write_reg(REG_REFERENCE_COUNT, '0);
    end_writes();
    // reference count zero, nothing loaded yet: answered as an empty store
    push_item(CMD_QUERY, 10'h3FF, 6'd0, 16'h8000, 1'b1);
    push_item(CMD_QUERY, 10'h000, 6'd1, 16'h7FFF, 1'b0);
    // entries 0 and 2 identical, entry 1 same values in the other sign class
    for (int n = 0; n < 3; n++) begin
      push_item(CMD_LOAD, 10'(n), 6'd0, 16'h7FFF, n != 1);
      push_item(CMD_LOAD, 10'(n), 6'd1, 16'h8000, 1'b0);
    end
    push_item(CMD_LOAD, 10'h3FF, 6'd0, 16'h0001, 1'b1);
    push_item(CMD_LOAD, 10'h3FF, 6'd1, 16'hFFFF, 1'b1);
    push_item(CMD_LOAD, 10'd5, 6'h3F, 16'h1234, 1'b1);
    push_item(CMD_QUERY, 10'h155, 6'h3F, 16'h0000, 1'b1);
    wait_drained();
    write_reg(REG_REFERENCE_COUNT, DIST_W'(3));
    end_writes();
    // full-scale difference on both elements
    push_item(CMD_QUERY, 10'h000, 6'd0, 16'h8000, 1'b1);
    push_item(CMD_QUERY, 10'h000, 6'd1, 16'h7FFF, 1'b1);
    // exact hit on entries 0 and 2, lowest index wins
    push_item(CMD_QUERY, 10'h2AA, 6'd0, 16'h7FFF, 1'b1);
    push_item(CMD_QUERY, 10'h000, 6'd1, 16'h8000, 1'b0);
    // only entry 1 shares the sign class
    push_item(CMD_QUERY, 10'h000, 6'd0, 16'h7FFF, 1'b0);
    push_item(CMD_QUERY, 10'h000, 6'd1, 16'h8000, 1'b1);
    wait_drained();
    write_reg(REG_MISMATCH_DISTANCE, '0);
    write_reg(REG_MATCH_THRESHOLD, '0);
    end_writes();
    // zero sentinel ties with the exact hit; zero threshold never matches
    push_item(CMD_QUERY, 10'h000, 6'd0, 16'h7FFF, 1'b0);
    push_item(CMD_QUERY, 10'h000, 6'd1, 16'h8000, 1'b0);
    wait_drained();
    write_reg(REG_MISMATCH_DISTANCE, DIST_ALL_ONES);
    write_reg(REG_MATCH_THRESHOLD, 39'd8589672450);
    end_writes();
    // distance equal to the threshold: not a match
    push_item(CMD_QUERY, 10'h000, 6'd0, 16'h8000, 1'b1);
    push_item(CMD_QUERY, 10'h000, 6'd1, 16'h7FFF, 1'b1);
    wait_drained();
    write_reg(REG_MATCH_THRESHOLD, 39'd8589672451);
    end_writes();
    push_item(CMD_QUERY, 10'h000, 6'd0, 16'h8000, 1'b1);
    push_item(CMD_QUERY, 10'h000, 6'd1, 16'h7FFF, 1'b1);

    // random part; an oversized length write acts as the maximum
    run_phase(4, 8, RST_MATCH_THRESHOLD, RST_MISMATCH_DISTANCE, 12, IDLE_SENDER);
    run_phase(127, 1, rand39(), '0, 1, IDLE_RECEIVER);
    run_phase(0, 24, '0, DIST_ALL_ONES, 6, IDLE_BOTH);
    run_phase(1, 32, 39'($urandom()), rand39(), 20, IDLE_NONE);
    run_phase(8, 12, RST_MATCH_THRESHOLD, RST_MISMATCH_DISTANCE, 6, IDLE_SENDER);
    run_phase(2, 40, 39'd274877906944, rand39(), 15, IDLE_RECEIVER);
    run_phase(3, 0, rand39(), rand39(), 4, IDLE_BOTH);
    run_phase(5, 20, RST_MATCH_THRESHOLD, 39'($urandom()), 10, IDLE_NONE);

    wait_drained();
    $display("covered %0d input transfers, %0d results checked", accepted_count, results_checked);
    $display("(%0d matched, %0d on an empty reference set)", matched_seen, empty_seen);
    if (errors == 0) begin
      $display("tb_descriptor_nearest_match_core: done, clean");
    end else begin
      $display("tb_descriptor_nearest_match_core: done, errors");
    end
    $finish;
  end

endmodule

### descriptor_nearest_match_core.f
+incdir+hdl
hdl/dnm_pkg.sv
hdl/dnm_ram.sv
hdl/dnm_ctrl.sv
hdl/dnm_datapath.sv
hdl/descriptor_nearest_match_core.sv
tb/tb_descriptor_nearest_match_core.sv
